### rtl/core/wflb_pkg.sv
// Shared types and constants of the weighted flow load balancer.
// No dependencies; imported by every module of the block.
`default_nettype none
package wflb_pkg;
  localparam int FLOW_ENTRIES = 64;
  localparam int MAX_SERVERS  = 6;
  localparam int WEIGHT_SLOTS = 6;
  localparam int IDX_W        = $clog2(FLOW_ENTRIES);
  localparam int CNT_W        = $clog2(FLOW_ENTRIES + 1);
  localparam int ADDR_W       = 5;

  localparam logic [3:0] MIN_HDR_WORDS = 4'd5;
  localparam logic [7:0] PROTO_TCP     = 8'd6;
  localparam logic [7:0] PROTO_UDP     = 8'd17;
  localparam logic [4:0] ETH_UDP_BYTES = 5'd22;  // Ethernet header plus UDP header

  typedef enum logic [2:0] {
    ST_KNOWN   = 3'd0,
    ST_NEW     = 3'd1,
    ST_BAD_IP  = 3'd2,
    ST_BAD_TCP = 3'd3,
    ST_BAD_UDP = 3'd4,
    ST_OTHER   = 3'd5,
    ST_FULL    = 3'd6
  } status_e;

  localparam logic [2:0] REG_SERVER_COUNT = 3'd0;

  typedef struct packed {
    logic [63:0] addrs;
    logic [31:0] ports;
    logic        udp;
  } flow_key_t;

  typedef struct packed {
    logic [6:0] flow;
    logic [2:0] server;
  } flow_ent_t;

  typedef struct packed {
    logic      hit;
    flow_ent_t ent;
  } chain_t;
endpackage
`default_nettype wire

### rtl/core/wflb_cell.sv
// One flow table cell: holds one entry, compares the broadcast key and
// ORs its hit into the result word handed to the next cell. Uses wflb_pkg.
`default_nettype none
module wflb_cell
  import wflb_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [IDX_W-1:0] cell_idx_i,
  input  wire flow_key_t        key_i,
  input  wire logic             cmp_en_i,
  input  wire logic             wr_en_i,
  input  wire logic [IDX_W-1:0] wr_idx_i,
  input  wire flow_ent_t        wr_ent_i,
  input  wire chain_t           chain_i,
  output chain_t                chain_o
);
  logic      valid_q;
  flow_key_t key_q;
  flow_ent_t ent_q;
  logic      hit_q;
  chain_t    chain_q, chain_d;
  logic      sel;

  assign sel = wr_en_i && (wr_idx_i == cell_idx_i);

  always_comb begin
    chain_d = chain_i;
    if (hit_q) begin
      chain_d.hit = 1'b1;
      chain_d.ent = chain_i.ent | ent_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      hit_q   <= 1'b0;
      chain_q <= '0;
    end else begin
      chain_q <= chain_d;
      if (cmp_en_i) hit_q <= valid_q && (key_q == key_i);
      if (sel) valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sel) begin
      key_q <= key_i;
      ent_q <= wr_ent_i;
    end
  end

  assign chain_o = chain_q;
endmodule
`default_nettype wire

### rtl/core/weighted_flow_load_balancer.sv
// Top level of the weighted flow load balancer: APB registers, control FSM,
// server selection and the row of wflb_cell table cells. Uses wflb_pkg.
//
// One header word in, one result word out. A dropped packet goes straight from
// acceptance to the decide state; a valid packet first passes the compare and
// scan states, the scan lasting while the hit word walks the full cell row, one
// cell per cycle. A new header is taken once the previous one has left the
// control FSM; the result waits in an output register. Flow entries are
// appended in order and never aged out; a new flow on a full table is dropped.
`default_nettype none
module weighted_flow_load_balancer
  import wflb_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [3:0]        ip_header_words_i,
  input  wire logic [7:0]        ip_protocol_i,
  input  wire logic [31:0]       source_address_i,
  input  wire logic [31:0]       dest_address_i,
  input  wire logic [15:0]       source_port_i,
  input  wire logic [15:0]       dest_port_i,
  input  wire logic [3:0]        tcp_header_words_i,
  input  wire logic [15:0]       frame_length_i,
  input  wire logic [15:0]       ip_total_length_i,
  input  wire logic [6:0]        random_draw_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [2:0]             status_o,
  output logic [31:0]            packet_id_o,
  output logic [6:0]             flow_id_o,
  output logic [2:0]             server_id_o,
  output logic [15:0]            packet_length_o
);
  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_CMP    = 4'b0010,
    S_SCAN   = 4'b0100,
    S_DECIDE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [2:0] srv_cnt_q;
  logic [6:0] weight_q [WEIGHT_SLOTS];
  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      srv_cnt_q <= 3'd1;
      for (int k = 0; k < WEIGHT_SLOTS; k++) weight_q[k] <= (k == 0) ? 7'd100 : 7'd0;
    end else if (cfg_wr) begin
      if (cfg_idx == REG_SERVER_COUNT) srv_cnt_q <= pwdata[2:0];
      for (int k = 0; k < WEIGHT_SLOTS; k++)
        if (cfg_idx == 3'(k + 1)) weight_q[k] <= pwdata[6:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (cfg_idx == REG_SERVER_COUNT) prdata = {29'd0, srv_cnt_q};
    for (int k = 0; k < WEIGHT_SLOTS; k++)
      if (cfg_idx == 3'(k + 1)) prdata = {25'd0, weight_q[k]};
  end

  // item registers
  flow_key_t  key_q;
  logic [6:0] draw_q;
  logic [15:0] len_q;
  status_e    bad_q;
  logic       is_bad_q;
  logic       accept;
  status_e    chk;
  logic       chk_bad;
  logic [16:0] udp_need;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign udp_need   = 17'(ETH_UDP_BYTES) + {11'd0, ip_header_words_i, 2'b00};

  always_comb begin
    chk     = ST_NEW;
    chk_bad = 1'b1;
    if (ip_header_words_i < MIN_HDR_WORDS) chk = ST_BAD_IP;
    else if (ip_protocol_i == PROTO_TCP) begin
      if (tcp_header_words_i < MIN_HDR_WORDS) chk = ST_BAD_TCP;
      else chk_bad = 1'b0;
    end else if (ip_protocol_i == PROTO_UDP) begin
      if ({1'b0, frame_length_i} < udp_need) chk = ST_BAD_UDP;
      else chk_bad = 1'b0;
    end else chk = ST_OTHER;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q.addrs <= {source_address_i, dest_address_i};
      key_q.ports <= {source_port_i, dest_port_i};
      key_q.udp   <= (ip_protocol_i == PROTO_UDP);
      draw_q      <= random_draw_i;
      len_q       <= ip_total_length_i;
      bad_q       <= chk;
    end
  end

  // scan counter and server selection
  logic [IDX_W-1:0] cnt_q;
  logic [2:0]       s_q;
  logic [9:0]       sum_q;
  logic             found_q;
  logic [2:0]       sel_srv_q;
  logic [2:0]       limit;
  logic [9:0]       sum_next;
  logic             sel_done, scan_done;

  assign limit     = (srv_cnt_q > 3'(MAX_SERVERS)) ? 3'(MAX_SERVERS) : srv_cnt_q;
  assign sum_next  = sum_q + {3'd0, weight_q[s_q]};
  assign sel_done  = found_q || (s_q >= limit);
  assign scan_done = (cnt_q == IDX_W'(FLOW_ENTRIES - 1)) && sel_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      s_q       <= '0;
      sum_q     <= '0;
      found_q   <= 1'b0;
      sel_srv_q <= '0;
      is_bad_q  <= 1'b0;
    end else if (accept) begin
      cnt_q    <= '0;
      s_q      <= '0;
      sum_q    <= '0;
      found_q  <= 1'b0;
      is_bad_q <= chk_bad;
    end else if (state_q == S_SCAN) begin
      if (cnt_q != IDX_W'(FLOW_ENTRIES - 1)) cnt_q <= cnt_q + 1'b1;
      if (!sel_done) begin
        if ({3'd0, draw_q} < sum_next) begin
          found_q   <= 1'b1;
          sel_srv_q <= s_q + 3'd1;
        end
        sum_q <= sum_next;
        s_q   <= s_q + 3'd1;
      end
    end
  end

  // cell row
  chain_t chain [FLOW_ENTRIES+1];
  logic [CNT_W-1:0] used_q;
  logic [6:0]       flows_q;
  logic [31:0]      pid_q;
  logic             wr_en;
  flow_ent_t        wr_ent;
  logic             emit;

  assign chain[0] = '0;

  for (genvar g = 0; g < FLOW_ENTRIES; g++) begin : g_cell
    wflb_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (IDX_W'(g)),
      .key_i      (key_q),
      .cmp_en_i   (state_q == S_CMP),
      .wr_en_i    (wr_en),
      .wr_idx_i   (used_q[IDX_W-1:0]),
      .wr_ent_i   (wr_ent),
      .chain_i    (chain[g]),
      .chain_o    (chain[g+1])
    );
  end

  chain_t     res;
  logic       full;
  logic [6:0] flows_inc;

  assign res       = chain[FLOW_ENTRIES];
  assign full      = (used_q == CNT_W'(FLOW_ENTRIES));
  assign flows_inc = flows_q + 7'd1;
  assign emit      = (state_q == S_DECIDE) && (!out_valid_o || out_ready_i);
  assign wr_en     = emit && !is_bad_q && !res.hit && !full;

  always_comb begin
    wr_ent.flow   = 7'd1;
    wr_ent.server = 3'd1;
    if (found_q) begin
      wr_ent.flow   = flows_inc;
      wr_ent.server = sel_srv_q;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (accept) state_d = chk_bad ? S_DECIDE : S_CMP;
      S_CMP:    state_d = S_SCAN;
      S_SCAN:   if (scan_done) state_d = S_DECIDE;
      S_DECIDE: if (emit) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      flows_q     <= '0;
      pid_q       <= 32'd1;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_ready_i) out_valid_o <= 1'b0;
      if (emit) begin
        out_valid_o <= 1'b1;
        if (!is_bad_q && (res.hit || !full)) pid_q <= pid_q + 32'd1;
        if (wr_en) begin
          used_q <= used_q + 1'b1;
          if (found_q) flows_q <= flows_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      status_o        <= bad_q;
      packet_id_o     <= '0;
      flow_id_o       <= '0;
      server_id_o     <= '0;
      packet_length_o <= '0;
      if (!is_bad_q) begin
        if (res.hit) begin
          status_o        <= ST_KNOWN;
          packet_id_o     <= pid_q;
          flow_id_o       <= res.ent.flow;
          server_id_o     <= res.ent.server;
          packet_length_o <= len_q;
        end else if (full) begin
          status_o <= ST_FULL;
        end else begin
          status_o        <= ST_NEW;
          packet_id_o     <= pid_q;
          flow_id_o       <= wr_ent.flow;
          server_id_o     <= wr_ent.server;
          packet_length_o <= len_q;
        end
      end
    end
  end
endmodule
`default_nettype wire

### rtl/core/wflb_checker.sv
// Port-level checks of the weighted flow load balancer, bound to the top.
// Uses wflb_pkg for status codes.
`default_nettype none
module wflb_checker
  import wflb_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [2:0]  status_o,
  input wire logic [31:0] packet_id_o,
  input wire logic [6:0]  flow_id_o,
  input wire logic [2:0]  server_id_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(packet_id_o))
    else $error("result word dropped or changed while stalled");

  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_KNOWN) && (status_o != ST_NEW)
      |-> (packet_id_o == 32'd0) && (flow_id_o == 7'd0) && (server_id_o == 3'd0))
    else $error("dropped packet carries ids");

  a_pass_ids: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((status_o == ST_KNOWN) || (status_o == ST_NEW))
      |-> (packet_id_o != 32'd0 || flow_id_o != 7'd0) && (server_id_o != 3'd0))
    else $error("accepted packet without server");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= ST_FULL)
    else $error("status code out of range");
endmodule

bind weighted_flow_load_balancer wflb_checker u_wflb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_o    (status_o),
  .packet_id_o (packet_id_o),
  .flow_id_o   (flow_id_o),
  .server_id_o (server_id_o)
);
`default_nettype wire

### tb/weighted_flow_load_balancer_tb.sv
// Self-checking testbench for weighted_flow_load_balancer: drives headers and
// APB register writes, predicts each result word in a scoreboard class.
// Depends on wflb_pkg and the block's RTL only.
`timescale 1ns / 100ps
module weighted_flow_load_balancer_tb;
  import wflb_pkg::*;

  localparam int REG_WEIGHT_BASE = 1;

  typedef struct {
    logic [3:0]  ihl;
    logic [7:0]  proto;
    logic [31:0] saddr;
    logic [31:0] daddr;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [3:0]  thl;
    logic [15:0] frame;
    logic [15:0] tot_len;
    logic [6:0]  draw;
  } header_t;

  typedef struct {
    status_e     status;
    logic [31:0] pkt_id;
    logic [6:0]  flow;
    logic [2:0]  server;
    logic [15:0] len;
  } verdict_t;

  class flow_scoreboard;
    logic [2:0]  srv_count;
    logic [6:0]  weight[WEIGHT_SLOTS];
    bit          used[FLOW_ENTRIES];
    logic [63:0] ent_addrs[FLOW_ENTRIES];
    logic [31:0] ent_ports[FLOW_ENTRIES];
    bit          ent_udp[FLOW_ENTRIES];
    logic [6:0]  ent_flow[FLOW_ENTRIES];
    logic [2:0]  ent_server[FLOW_ENTRIES];
    int          n_used;
    logic [6:0]  flows_issued;
    logic [31:0] next_pkt;
    verdict_t    pending[$];
    int          errors;

    function new();
      srv_count = 1;
      foreach (weight[k]) weight[k] = 0;
      weight[0] = 100;
      foreach (used[k]) used[k] = 0;
      n_used = 0;
      flows_issued = 0;
      next_pkt = 1;
      errors = 0;
    endfunction

    function void write_reg(int idx, logic [31:0] val);
      if (idx == REG_SERVER_COUNT) srv_count = val[2:0];
      else if (idx <= WEIGHT_SLOTS) weight[idx-1] = val[6:0];
    endfunction

    function void drop(status_e st);
      verdict_t v;
      v.status = st; v.pkt_id = 0; v.flow = 0; v.server = 0; v.len = 0;
      pending.insert(pending.size(), v);
    endfunction

    function void note_header(header_t h);
      int ip_bytes, lim, sum, hit;
      bit udp;
      logic [63:0] a;
      logic [31:0] p;
      verdict_t v;
      ip_bytes = h.ihl * 4;
      a = {h.saddr, h.daddr};
      p = {h.sport, h.dport};
      hit = -1;
      if (h.ihl < 5) begin drop(ST_BAD_IP); return; end
      if (h.proto == PROTO_TCP) begin
        if (h.thl < 5) begin drop(ST_BAD_TCP); return; end
        udp = 0;
      end else if (h.proto == PROTO_UDP) begin
        if (int'(h.frame) < 14 + ip_bytes + 8) begin drop(ST_BAD_UDP); return; end
        udp = 1;
      end else begin
        drop(ST_OTHER); return;
      end
      for (int k = 0; k < FLOW_ENTRIES; k++)
        if (hit < 0 && used[k] && ent_addrs[k] == a && ent_ports[k] == p && ent_udp[k] == udp)
          hit = k;
      if (hit >= 0) begin
        v.status = ST_KNOWN; v.flow = ent_flow[hit]; v.server = ent_server[hit];
      end else begin
        if (n_used >= FLOW_ENTRIES) begin drop(ST_FULL); return; end
        v.status = ST_NEW; v.flow = 7'd1; v.server = 3'd1;
        lim = (srv_count > MAX_SERVERS) ? MAX_SERVERS : srv_count;
        sum = 0;
        for (int s = 0; s < lim; s++) begin
          if (int'(h.draw) < int'(weight[s]) + sum) begin
            v.server = 3'(s + 1);
            flows_issued = flows_issued + 7'd1;
            v.flow = flows_issued;
            break;
          end
          sum += weight[s];
        end
        used[n_used] = 1; ent_addrs[n_used] = a; ent_ports[n_used] = p;
        ent_udp[n_used] = udp; ent_flow[n_used] = v.flow; ent_server[n_used] = v.server;
        n_used++;
      end
      v.pkt_id = next_pkt;
      v.len = h.tot_len;
      next_pkt = next_pkt + 32'd1;
      pending.insert(pending.size(), v);
    endfunction

    function void check_result(verdict_t got);
      verdict_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result status=%0d", $time, got.status);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status || got.pkt_id !== e.pkt_id || got.flow !== e.flow ||
          got.server !== e.server || got.len !== e.len) begin
        $display("%0t: mismatch exp st=%0d id=%0d fl=%0d sv=%0d len=%0d", $time,
                 e.status, e.pkt_id, e.flow, e.server, e.len);
        $display("%0t:          got st=%0d id=%0d fl=%0d sv=%0d len=%0d", $time,
                 got.status, got.pkt_id, got.flow, got.server, got.len);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic pready;
  logic in_valid_i = 0, in_ready_o, out_valid_o, out_ready_i = 0;
  logic [3:0] ip_header_words_i = 0, tcp_header_words_i = 0;
  logic [7:0] ip_protocol_i = 0;
  logic [31:0] source_address_i = 0, dest_address_i = 0;
  logic [15:0] source_port_i = 0, dest_port_i = 0, frame_length_i = 0;
  logic [15:0] ip_total_length_i = 0;
  logic [6:0] random_draw_i = 0;
  logic [2:0] status_o, server_id_o;
  logic [31:0] packet_id_o;
  logic [6:0] flow_id_o;
  logic [15:0] packet_length_o;

  int send_idle_pct = 0, recv_stall_pct = 0;
  flow_scoreboard sb = new();
  header_t known_flows[$];

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  weighted_flow_load_balancer DUT (.*);

  // result side: random stall, check each word taken
  always @(posedge clk_i) begin
    verdict_t r;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        r.status = status_e'(status_o); r.pkt_id = packet_id_o; r.flow = flow_id_o;
        r.server = server_id_o; r.len = packet_length_o;
        sb.check_result(r);
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic apb_write(int idx, logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= ADDR_W'(4 * idx); pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.write_reg(idx, val);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  // valid stays high between back-to-back words; drops only for idle cycles
  task automatic send_header(header_t h);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1;
    ip_header_words_i <= h.ihl; ip_protocol_i <= h.proto;
    source_address_i <= h.saddr; dest_address_i <= h.daddr;
    source_port_i <= h.sport; dest_port_i <= h.dport;
    tcp_header_words_i <= h.thl; frame_length_i <= h.frame;
    ip_total_length_i <= h.tot_len; random_draw_i <= h.draw;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_header(h);
  endtask

  function automatic header_t good_header(bit udp);
    header_t h;
    h.ihl = $urandom_range(15, 5);
    h.proto = udp ? PROTO_UDP : PROTO_TCP;
    h.saddr = $urandom; h.daddr = $urandom;
    h.sport = $urandom; h.dport = $urandom;
    h.thl = $urandom_range(15, 5);
    h.frame = $urandom_range(65535, 82);
    h.tot_len = $urandom;
    h.draw = ($urandom_range(19) == 0) ? $urandom_range(127, 100) : $urandom_range(99);
    return h;
  endfunction

  function automatic header_t random_header();
    header_t h;
    int pick;
    pick = $urandom_range(99);
    if (pick < 30 && known_flows.size() > 0) begin
      h = known_flows[$urandom_range(known_flows.size() - 1)];
      h.tot_len = $urandom; h.draw = $urandom;
      if (h.proto == PROTO_UDP) h.frame = $urandom_range(65535, 82);
      else h.frame = $urandom;
    end else if (pick < 75) begin
      h = good_header($urandom_range(1));
    end else begin
      h.ihl = $urandom; h.proto = $urandom_range(1) ? PROTO_UDP : 8'($urandom);
      h.saddr = $urandom; h.daddr = $urandom; h.sport = $urandom; h.dport = $urandom;
      h.thl = $urandom; h.frame = $urandom_range(1) ? $urandom_range(90) : $urandom;
      h.tot_len = $urandom; h.draw = $urandom;
    end
    return h;
  endfunction

  task automatic run_random(int count);
    header_t h;
    for (int k = 0; k < count; k++) begin
      h = random_header();
      send_header(h);
      if (h.ihl >= 5 && (h.proto == PROTO_TCP || h.proto == PROTO_UDP) && known_flows.size() < 40)
        known_flows.insert(known_flows.size(), h);
    end
  endtask

  task automatic program_weights(logic [2:0] cnt, int w0, int w1, int w2, int w3,
                                 int w4, int w5);
    apb_write(REG_SERVER_COUNT, cnt);
    apb_write(REG_WEIGHT_BASE + 0, w0); apb_write(REG_WEIGHT_BASE + 1, w1);
    apb_write(REG_WEIGHT_BASE + 2, w2); apb_write(REG_WEIGHT_BASE + 3, w3);
    apb_write(REG_WEIGHT_BASE + 4, w4); apb_write(REG_WEIGHT_BASE + 5, w5);
  endtask

  initial begin
    header_t h;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: drop codes and edges, default config
    h = good_header(0); h.ihl = 4; send_header(h);
    h = good_header(0); h.ihl = 0; send_header(h);
    h = good_header(0); h.thl = 4; send_header(h);
    h = good_header(0); h.thl = 15; h.ihl = 15; send_header(h);
    send_header(h);
    h = good_header(1); h.ihl = 5; h.frame = 41; send_header(h);
    h.frame = 42; send_header(h);
    h = good_header(1); h.ihl = 15; h.frame = 81; send_header(h);
    h.frame = 16'hffff; h.saddr = '1; h.daddr = '1; h.sport = '1; h.dport = '1;
    h.tot_len = '1; send_header(h);
    h.proto = PROTO_TCP; send_header(h);
    h = good_header(0); h.proto = 8'hff; send_header(h);
    h.proto = 0; send_header(h);
    h = good_header(0); h.saddr = 0; h.daddr = 0; h.sport = 0; h.dport = 0;
    h.tot_len = 0; h.draw = 127; send_header(h);
    h = good_header(0); h.draw = 100; send_header(h);
    h = good_header(0); h.draw = 99; send_header(h);
    drain();

    program_weights(6, 10, 20, 30, 15, 5, 20);
    for (int k = 0; k < 8; k++) begin
      h = good_header(k[0]); h.draw = k * 14; send_header(h);
    end
    drain();
    program_weights(0, 100, 100, 100, 100, 100, 100);
    h = good_header(0); h.draw = 0; send_header(h);
    drain();
    program_weights(7, 0, 0, 0, 0, 0, 100);
    h = good_header(1); h.draw = 50; send_header(h);
    drain();

    program_weights(3, 40, 40, 20, 0, 0, 0);
    run_random(150);
    drain();  // sender pauses until all results are in
    send_idle_pct = 70;
    program_weights(6, 0, 0, 0, 0, 0, 0);
    run_random(150);
    drain();
    send_idle_pct = 0; recv_stall_pct = 70;
    program_weights(2, 100, 0, 50, 50, 0, 0);
    run_random(150);
    drain();
    send_idle_pct = 7; recv_stall_pct = 7;
    program_weights(5, 17, 17, 17, 17, 32, 100);
    run_random(150);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end
endmodule

### files.f
rtl/core/wflb_pkg.sv
rtl/core/wflb_cell.sv
rtl/core/weighted_flow_load_balancer.sv
rtl/core/wflb_checker.sv
tb/weighted_flow_load_balancer_tb.sv
